// ===== rtl/saf_pkg.sv =====
package saf_pkg;

   localparam int MAX_MSG_BYTES_DEFAULT = 1024;

   // offsets inside a message are bounded by the 16-bit length fields
   localparam int OFF_W = 18;
   localparam int HDR_BYTES = 20;

   localparam logic [31:0] STUN_COOKIE = 32'h2112A442;
   localparam logic [15:0] PORT_MASK = 16'h2112;

   localparam logic [2:0] STATUS_OK = 3'd0;
   localparam logic [2:0] STATUS_NOT_STUN = 3'd1;
   localparam logic [2:0] STATUS_NOT_FOUND = 3'd2;
   localparam logic [2:0] STATUS_SHORT_ATTR = 3'd3;
   localparam logic [2:0] STATUS_BAD_FAMILY = 3'd4;
   localparam logic [2:0] STATUS_TRUNCATED = 3'd5;

   localparam logic [1:0] FAMILY_NONE = 2'd0;
   localparam logic [1:0] FAMILY_IPV4 = 2'd1;
   localparam logic [1:0] FAMILY_IPV6 = 2'd2;

   localparam logic [15:0] ATTR_TYPE_DEFAULT = 16'h0020;
   localparam logic XOR_MODE_DEFAULT = 1'b1;

   localparam int KNOWN_TYPE_COUNT = 21;
   localparam logic [15:0] KNOWN_TYPES [KNOWN_TYPE_COUNT] = '{
      16'h0017, 16'h0016, 16'h0001, 16'h0003, 16'h0004, 16'h0009, 16'h0002,
      16'h0008, 16'h0011, 16'h0101, 16'h0102, 16'h0103, 16'h0104, 16'h0108,
      16'h0109, 16'h0113, 16'h0112, 16'h0114, 16'h0118, 16'h0111, 16'h0119
   };

   typedef struct packed {
      logic [15:0] wanted_attr_type;
      logic        xor_mode;
   } saf_cfg_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [15:0] msg_type;
      logic        type_known;
      logic [1:0]  addr_family;
      logic [15:0] port_number;
      logic [63:0] addr_hi;
      logic [63:0] addr_lo;
      logic        pair;
   } saf_result_type;

   function automatic logic type_is_known(logic [15:0] t);
      logic hit;
      hit = 1'b0;
      for (int i = 0; i < KNOWN_TYPE_COUNT; i++) begin
         if (KNOWN_TYPES[i] == t) begin
            hit = 1'b1;
         end
      end
      return hit;
   endfunction

endpackage

// ===== rtl/saf_ifs.sv =====
interface saf_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] msg_byte;
   logic       is_last;

   modport source(output valid, output msg_byte, output is_last, input ready);
   modport sink(input valid, input msg_byte, input is_last, output ready);
endinterface

interface saf_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [15:0] msg_type;
   logic        type_known;
   logic [1:0]  addr_family;
   logic [15:0] port_number;
   logic [63:0] addr_word;
   logic        word_index;
   logic        last_result;

   modport source(output valid, output status, output msg_type, output type_known,
                  output addr_family, output port_number, output addr_word,
                  output word_index, output last_result, input ready);
   modport sink(input valid, input status, input msg_type, input type_known,
                input addr_family, input port_number, input addr_word,
                input word_index, input last_result, output ready);
endinterface

// ===== rtl/saf_csr.sv =====
module saf_csr (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [2:0]           paddr,
   input  logic [31:0]          pwdata,
   output logic [31:0]          prdata,
   output logic                 pready,
   output saf_pkg::saf_cfg_type cfg
);

   localparam logic REG_WANTED_ATTR = 1'b0;
   localparam logic REG_XOR_MODE = 1'b1;

   logic [15:0] wanted_ff;
   logic        xor_ff;
   logic        wr_en;

   assign pready = 1'b1;
   assign wr_en = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         wanted_ff <= saf_pkg::ATTR_TYPE_DEFAULT;
         xor_ff <= saf_pkg::XOR_MODE_DEFAULT;
      end else if (wr_en) begin
         unique case (paddr[2])
            REG_WANTED_ATTR: wanted_ff <= pwdata[15:0];
            REG_XOR_MODE:    xor_ff <= pwdata[0];
            default:         ;
         endcase
      end
   end

   always_comb begin
      prdata = '0;
      unique case (paddr[2])
         REG_WANTED_ATTR: prdata = {16'h0000, wanted_ff};
         REG_XOR_MODE:    prdata = {31'h0, xor_ff};
         default:         prdata = '0;
      endcase
   end

   assign cfg.wanted_attr_type = wanted_ff;
   assign cfg.xor_mode = xor_ff;

endmodule

// ===== rtl/saf_parse.sv =====
module saf_parse #(
   parameter int MAX_MSG_BYTES = saf_pkg::MAX_MSG_BYTES_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  saf_pkg::saf_cfg_type    cfg,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  logic [7:0]              in_byte,
   input  logic                    in_last,
   output logic                    res_push,
   input  logic                    res_room,
   output saf_pkg::saf_result_type res_data
);

   localparam int POS_W = $clog2(MAX_MSG_BYTES + 22);
   localparam int OFF_W = saf_pkg::OFF_W;

   logic                 vld_ff;
   logic [7:0]           byte_ff;
   logic                 last_ff;
   logic                 advance;

   logic [POS_W-1:0]     pos_ff, pos_in;
   logic [15:0]          htype_ff, htype_in;
   logic [15:0]          hlen_ff, hlen_in;
   logic                 hvalid_ff, hvalid_in;
   logic [OFF_W-1:0]     nxt_ff, nxt_in;
   logic [31:0]          shift_ff, shift_in;
   logic [OFF_W-1:0]     found_ff, found_in;
   logic [95:0]          tid_ff, tid_in;
   logic [63:0]          addr_ff [2];
   logic [63:0]          addr_in [2];
   logic [31:0]          fp_ff, fp_in;

   logic [OFF_W-1:0]     p, eom, eom_in, count;
   logic [4:0]           j;
   logic [3:0]           k;
   logic [15:0]          alen, fam, port;
   logic [31:0]          ip4;

   assign advance = vld_ff && (!last_ff || res_room);
   assign in_ready = !vld_ff || advance;
   assign res_push = advance && last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (in_valid && in_ready) begin
         vld_ff <= 1'b1;
      end else if (advance) begin
         vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         byte_ff <= in_byte;
         last_ff <= in_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (advance && last_ff)) begin
         pos_ff <= '0;
         htype_ff <= '0;
         hlen_ff <= '0;
         hvalid_ff <= 1'b1;
         nxt_ff <= OFF_W'(saf_pkg::HDR_BYTES);
         shift_ff <= '0;
         found_ff <= '0;
         addr_ff[0] <= '0;
         addr_ff[1] <= '0;
         fp_ff <= '0;
      end else if (advance) begin
         pos_ff <= pos_in;
         htype_ff <= htype_in;
         hlen_ff <= hlen_in;
         hvalid_ff <= hvalid_in;
         nxt_ff <= nxt_in;
         shift_ff <= shift_in;
         found_ff <= found_in;
         addr_ff[0] <= addr_in[0];
         addr_ff[1] <= addr_in[1];
         fp_ff <= fp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         tid_ff <= tid_in;
      end
   end

   always_comb begin
      p = OFF_W'(pos_ff);
      eom = OFF_W'(saf_pkg::HDR_BYTES) + OFF_W'(hlen_ff);
      htype_in = htype_ff;
      hlen_in = hlen_ff;
      hvalid_in = hvalid_ff;
      nxt_in = nxt_ff;
      shift_in = shift_ff;
      found_in = found_ff;
      tid_in = tid_ff;
      addr_in[0] = addr_ff[0];
      addr_in[1] = addr_ff[1];
      fp_in = fp_ff;
      j = 5'(p - found_ff - OFF_W'(4));
      k = 4'(j - 5'd4);

      if (p == OFF_W'(0)) begin
         htype_in = {byte_ff, 8'h00};
         if (byte_ff >= 8'd3) begin
            hvalid_in = 1'b0;
         end
      end else if (p == OFF_W'(1)) begin
         htype_in = {htype_ff[15:8], byte_ff};
      end else if (p == OFF_W'(2)) begin
         hlen_in = {byte_ff, 8'h00};
      end else if (p == OFF_W'(3)) begin
         hlen_in = {hlen_ff[15:8], byte_ff};
         if (hlen_in > 16'(MAX_MSG_BYTES)) begin
            hvalid_in = 1'b0;
         end
      end else if (p < OFF_W'(8)) begin
         if (byte_ff != saf_pkg::STUN_COOKIE[{~p[1:0], 3'b000} +: 8]) begin
            hvalid_in = 1'b0;
         end
      end else if (p < OFF_W'(saf_pkg::HDR_BYTES)) begin
         tid_in = {tid_ff[87:0], byte_ff};
      end else if (p < eom) begin
         if (found_ff == '0) begin
            if (p >= nxt_ff && (nxt_ff + OFF_W'(4)) <= eom) begin
               shift_in = {shift_ff[23:0], byte_ff};
               if (p == nxt_ff + OFF_W'(3)) begin
                  if (shift_in[31:16] == cfg.wanted_attr_type) begin
                     found_in = nxt_ff;
                  end else begin
                     nxt_in = nxt_ff + OFF_W'(4)
                            + ((OFF_W'(shift_in[15:0]) + OFF_W'(3)) & ~OFF_W'(3));
                  end
               end
            end
         end else if (p >= found_ff + OFF_W'(4) && p < found_ff + OFF_W'(24)) begin
            if (j < 5'd4) begin
               fp_in[{~j[1:0], 3'b000} +: 8] = byte_ff;
            end else begin
               addr_in[k[3]][{~k[2:0], 3'b000} +: 8] = byte_ff;
            end
         end
      end

      pos_in = (pos_ff == '1) ? pos_ff : pos_ff + POS_W'(1);
   end

   always_comb begin
      count = OFF_W'(pos_in);
      eom_in = OFF_W'(saf_pkg::HDR_BYTES) + OFF_W'(hlen_in);
      alen = shift_in[15:0];
      fam = fp_in[31:16];
      port = fp_in[15:0] ^ (cfg.xor_mode ? saf_pkg::PORT_MASK : 16'h0000);
      ip4 = addr_in[0][63:32] ^ (cfg.xor_mode ? saf_pkg::STUN_COOKIE : 32'h0);

      res_data.status = saf_pkg::STATUS_OK;
      res_data.msg_type = htype_in;
      res_data.type_known = saf_pkg::type_is_known(htype_in);
      res_data.addr_family = saf_pkg::FAMILY_NONE;
      res_data.port_number = '0;
      res_data.addr_hi = '0;
      res_data.addr_lo = '0;
      res_data.pair = 1'b0;

      if (count < OFF_W'(saf_pkg::HDR_BYTES) || !hvalid_in) begin
         res_data.status = saf_pkg::STATUS_NOT_STUN;
      end else if (count < eom_in) begin
         res_data.status = saf_pkg::STATUS_TRUNCATED;
      end else if (found_in == '0) begin
         res_data.status = saf_pkg::STATUS_NOT_FOUND;
      end else if (fam == 16'd1) begin
         if (alen < 16'd8) begin
            res_data.status = saf_pkg::STATUS_SHORT_ATTR;
         end else begin
            res_data.addr_family = saf_pkg::FAMILY_IPV4;
            res_data.port_number = port;
            res_data.addr_hi = {32'h0, ip4};
         end
      end else if (fam == 16'd2) begin
         if (alen < 16'd20) begin
            res_data.status = saf_pkg::STATUS_SHORT_ATTR;
         end else begin
            res_data.addr_family = saf_pkg::FAMILY_IPV6;
            res_data.port_number = port;
            res_data.pair = 1'b1;
            res_data.addr_hi = addr_in[0]
               ^ (cfg.xor_mode ? {saf_pkg::STUN_COOKIE, tid_in[95:64]} : 64'h0);
            res_data.addr_lo = addr_in[1] ^ (cfg.xor_mode ? tid_in[63:0] : 64'h0);
         end
      end else begin
         res_data.status = saf_pkg::STATUS_BAD_FAMILY;
      end
   end

endmodule

// ===== rtl/saf_out.sv =====
module saf_out (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    res_push,
   output logic                    res_room,
   input  saf_pkg::saf_result_type res_data,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [2:0]              rsp_status,
   output logic [15:0]             rsp_msg_type,
   output logic                    rsp_type_known,
   output logic [1:0]              rsp_addr_family,
   output logic [15:0]             rsp_port_number,
   output logic [63:0]             rsp_addr_word,
   output logic                    rsp_word_index,
   output logic                    rsp_last_result
);

   logic                    valid_ff;
   logic                    idx_ff;
   saf_pkg::saf_result_type res_ff;
   logic                    last_out;
   logic                    taken;

   assign last_out = !res_ff.pair || idx_ff;
   assign taken = valid_ff && rsp_ready;
   assign res_room = !valid_ff || (taken && last_out);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff <= 1'b0;
      end else if (res_push) begin
         valid_ff <= 1'b1;
         idx_ff <= 1'b0;
      end else if (taken && last_out) begin
         valid_ff <= 1'b0;
      end else if (taken) begin
         idx_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (res_push) begin
         res_ff <= res_data;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_status = res_ff.status;
   assign rsp_msg_type = res_ff.msg_type;
   assign rsp_type_known = res_ff.type_known;
   assign rsp_addr_family = res_ff.addr_family;
   assign rsp_port_number = res_ff.port_number;
   assign rsp_addr_word = idx_ff ? res_ff.addr_lo : res_ff.addr_hi;
   assign rsp_word_index = idx_ff;
   assign rsp_last_result = last_out;

endmodule

// ===== rtl/stun_attribute_finder.sv =====
// STUN attribute finder.
// req_chan carries one message byte per request, is_last marking the final
// byte of a message. Bytes are taken at one per cycle while req_chan.ready is
// high, with no gap between messages. rsp_chan returns one result per message,
// or two for an IPv6 address (upper half first, then lower half, last_result on
// the second). The first result goes from the input register to the result
// register; the second IPv6 half follows in the cycle after the first is taken.
// The APB port holds the wanted attribute type (address 0) and the xor mode
// (address 4); write them only while no message is in flight.
// Reset returns the registers to type 0x0020 and xor mode on, drops any
// partial message and empties the result register.
// When the receiver stalls, the result is held; bytes keep flowing until a
// last byte reaches the parse stage while the result register is still full,
// and then req_chan.ready drops until the result register frees.
module stun_attribute_finder #(
   parameter int MAX_MSG_BYTES = saf_pkg::MAX_MSG_BYTES_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   saf_req_if.sink     req_chan,
   saf_rsp_if.source   rsp_chan,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   saf_pkg::saf_cfg_type    cfg;
   saf_pkg::saf_result_type res_data;
   logic                    res_push;
   logic                    res_room;

   saf_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   saf_parse #(
      .MAX_MSG_BYTES (MAX_MSG_BYTES)
   ) u_parse (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .in_valid (req_chan.valid),
      .in_ready (req_chan.ready),
      .in_byte  (req_chan.msg_byte),
      .in_last  (req_chan.is_last),
      .res_push (res_push),
      .res_room (res_room),
      .res_data (res_data)
   );

   saf_out u_out (
      .clock           (clock),
      .reset           (reset),
      .res_push        (res_push),
      .res_room        (res_room),
      .res_data        (res_data),
      .rsp_valid       (rsp_chan.valid),
      .rsp_ready       (rsp_chan.ready),
      .rsp_status      (rsp_chan.status),
      .rsp_msg_type    (rsp_chan.msg_type),
      .rsp_type_known  (rsp_chan.type_known),
      .rsp_addr_family (rsp_chan.addr_family),
      .rsp_port_number (rsp_chan.port_number),
      .rsp_addr_word   (rsp_chan.addr_word),
      .rsp_word_index  (rsp_chan.word_index),
      .rsp_last_result (rsp_chan.last_result)
   );

endmodule
